// ===== rtl/vdma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdma_pkg
// Shared types, codes and default sizes of the video DMA transfer engine.
// ----------------------------------------------------------------------------
package vdma_pkg;

	localparam int VIDEO_BYTES_DEF  = 65536;
	localparam int COLOUR_BYTES_DEF = 128;
	localparam int SCROLL_BYTES_DEF = 128;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_STEP  = 2'd1,
		REQ_READ  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		SEL_VIDEO  = 2'd0,
		SEL_COLOUR = 2'd1,
		SEL_SCROLL = 2'd2
	} store_sel_t;

	typedef enum logic [2:0] {
		K_FILL = 3'd0,
		K_COPY = 3'd1,
		K_MVID = 3'd2,
		K_MCOL = 3'd3,
		K_MSCR = 3'd4,
		K_NONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_STARTED  = 3'd1,
		ST_MOVED    = 3'd2,
		ST_FINISHED = 3'd3,
		ST_ABORTED  = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	// Command code fields: bits 7:6 mode, bits 4:2 target.
	localparam logic [1:0] MODE_FILL = 2'b10;
	localparam logic [1:0] MODE_COPY = 2'b11;
	localparam logic [2:0] TGT_VIDEO  = 3'd1;
	localparam logic [2:0] TGT_COLOUR = 3'd3;
	localparam logic [2:0] TGT_SCROLL = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  cmd_code;
		logic [15:0] dest_address;
		logic [31:0] source_value;
		logic [15:0] transfer_length;
		logic [7:0]  mem_byte;
		logic        mem_present;
		logic [1:0]  read_store;
		logic [15:0] read_addr;
	} req_t;

	typedef struct packed {
		logic        busy;
		kind_t       kind;
		logic [31:0] next_source;
		status_t     status;
	} res_t;

	// Memory actions of one item, handed from the control unit to the datapath.
	typedef struct packed {
		logic        rd_en;
		store_sel_t  rd_sel;
		logic [15:0] rd_addr;
		logic        is_read;
		logic        wr_en;
		store_sel_t  wr_sel;
		logic [15:0] wr_addr;
		logic        wr_copy;
		logic [7:0]  wr_byte;
		res_t        res;
	} act_t;

endpackage

// ===== rtl/vdma_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdma_req_if / vdma_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface vdma_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  cmd_code;
	logic [15:0] dest_address;
	logic [31:0] source_value;
	logic [15:0] transfer_length;
	logic [7:0]  mem_byte;
	logic        mem_present;
	logic [1:0]  read_store;
	logic [15:0] read_addr;

	modport source (
		output valid, req_type, cmd_code, dest_address, source_value,
		       transfer_length, mem_byte, mem_present, read_store, read_addr,
		input  ready
	);
	modport sink (
		input  valid, req_type, cmd_code, dest_address, source_value,
		       transfer_length, mem_byte, mem_present, read_store, read_addr,
		output ready
	);
endinterface

interface vdma_res_if;
	logic        valid;
	logic        ready;
	logic        busy_res;
	logic [2:0]  kind;
	logic [31:0] next_source;
	logic [2:0]  status;
	logic [7:0]  read_data;

	modport source (
		output valid, busy_res, kind, next_source, status, read_data,
		input  ready
	);
	modport sink (
		input  valid, busy_res, kind, next_source, status, read_data,
		output ready
	);
endinterface

// ===== rtl/vdma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdma_ram
// Byte-wide synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vdma_ram #(
	parameter int DEPTH = vdma_pkg::COLOUR_BYTES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/vdma_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdma_ctrl
// Transfer registers and request decode: works out the result fields and the
// store accesses of each accepted word and advances the transfer state.
// ----------------------------------------------------------------------------
module vdma_ctrl #(
	parameter int VIDEO_BYTES  = vdma_pkg::VIDEO_BYTES_DEF,
	parameter int COLOUR_BYTES = vdma_pkg::COLOUR_BYTES_DEF,
	parameter int SCROLL_BYTES = vdma_pkg::SCROLL_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  vdma_pkg::req_t req,
	output vdma_pkg::act_t act
);

	localparam logic [15:0] VMASK = 16'(VIDEO_BYTES - 1);
	localparam logic [15:0] CMASK = 16'(COLOUR_BYTES - 1);
	localparam logic [15:0] SMASK = 16'(SCROLL_BYTES - 1);

	logic                active_q, active_d;
	vdma_pkg::kind_t     kind_q, kind_d;
	logic [15:0]         dest_q, dest_d;
	logic [31:0]         src_q, src_d;
	logic [15:0]         left_q, left_d;
	logic [7:0]          fill_q, fill_d;

	function automatic logic [15:0] mask_of(input vdma_pkg::kind_t k);
		logic [15:0] m;
		if (k == vdma_pkg::K_MCOL) begin
			m = CMASK;
		end else if (k == vdma_pkg::K_MSCR) begin
			m = SMASK;
		end else begin
			m = VMASK;
		end
		return m;
	endfunction

	always_comb begin
		vdma_pkg::kind_t k;
		logic [15:0]     full;
		logic [15:0]     d;
		logic            moved;

		active_d = active_q;
		kind_d   = kind_q;
		dest_d   = dest_q;
		src_d    = src_q;
		left_d   = left_q;
		fill_d   = fill_q;
		k        = kind_q;
		full     = {req.cmd_code[1:0] | req.dest_address[15:14], req.dest_address[13:0]};
		d        = dest_q & mask_of(kind_q);
		moved    = 1'b0;

		act            = '0;
		act.rd_sel     = vdma_pkg::SEL_VIDEO;
		act.wr_sel     = vdma_pkg::SEL_VIDEO;
		act.res.kind   = kind_q;
		act.res.status = vdma_pkg::ST_IGNORED;

		unique case (req.req_type)
			vdma_pkg::REQ_START: begin
				if (req.cmd_code[7:6] == vdma_pkg::MODE_FILL) begin
					k      = vdma_pkg::K_FILL;
					fill_d = req.source_value[7:0];
					src_d  = '0;
				end else if (req.cmd_code[7:6] == vdma_pkg::MODE_COPY) begin
					k     = vdma_pkg::K_COPY;
					src_d = {16'd0, req.source_value[15:0] & VMASK};
				end else begin
					src_d = req.source_value;
					priority if (req.cmd_code[4:2] == vdma_pkg::TGT_VIDEO) begin
						k = vdma_pkg::K_MVID;
					end else if (req.cmd_code[4:2] == vdma_pkg::TGT_COLOUR) begin
						k = vdma_pkg::K_MCOL;
					end else if (req.cmd_code[4:2] == vdma_pkg::TGT_SCROLL) begin
						k = vdma_pkg::K_MSCR;
					end else begin
						k = vdma_pkg::K_NONE;
					end
				end
				dest_d       = full & mask_of(k);
				act.res.kind = k;
				if (k == vdma_pkg::K_NONE || req.transfer_length == 16'd0) begin
					active_d       = 1'b0;
					left_d         = '0;
					kind_d         = vdma_pkg::K_NONE;
					act.res.status = vdma_pkg::ST_FINISHED;
				end else begin
					active_d       = 1'b1;
					left_d         = req.transfer_length;
					kind_d         = k;
					act.res.status = vdma_pkg::ST_STARTED;
				end
			end
			vdma_pkg::REQ_STEP: begin
				if (active_q && kind_q != vdma_pkg::K_NONE) begin
					act.wr_addr = d;
					priority case (kind_q)
						vdma_pkg::K_FILL: begin
							act.wr_en   = 1'b1;
							act.wr_byte = fill_q;
							moved       = 1'b1;
						end
						vdma_pkg::K_COPY: begin
							act.rd_en   = 1'b1;
							act.rd_addr = src_q[15:0] & VMASK;
							act.wr_en   = 1'b1;
							act.wr_copy = 1'b1;
							src_d       = {16'd0, (src_q[15:0] + 16'd1) & VMASK};
							moved       = 1'b1;
						end
						default: begin
							if (!req.mem_present) begin
								active_d       = 1'b0;
								left_d         = '0;
								kind_d         = vdma_pkg::K_NONE;
								act.res.status = vdma_pkg::ST_ABORTED;
							end else begin
								act.wr_en   = 1'b1;
								act.wr_byte = req.mem_byte;
								if (kind_q == vdma_pkg::K_MCOL) begin
									act.wr_sel = vdma_pkg::SEL_COLOUR;
								end else if (kind_q == vdma_pkg::K_MSCR) begin
									act.wr_sel = vdma_pkg::SEL_SCROLL;
								end
								src_d = src_q + 32'd1;
								moved = 1'b1;
							end
						end
					endcase
					if (moved) begin
						dest_d = (d + 16'd1) & mask_of(kind_q);
						left_d = left_q - 16'd1;
						if (left_d == 16'd0) begin
							active_d       = 1'b0;
							kind_d         = vdma_pkg::K_NONE;
							act.res.status = vdma_pkg::ST_FINISHED;
						end else begin
							act.res.status = vdma_pkg::ST_MOVED;
						end
					end
				end
			end
			vdma_pkg::REQ_READ: begin
				unique case (req.read_store)
					vdma_pkg::SEL_VIDEO: begin
						act.rd_en   = 1'b1;
						act.rd_sel  = vdma_pkg::SEL_VIDEO;
						act.rd_addr = req.read_addr & VMASK;
						act.is_read = 1'b1;
					end
					vdma_pkg::SEL_COLOUR: begin
						act.rd_en   = 1'b1;
						act.rd_sel  = vdma_pkg::SEL_COLOUR;
						act.rd_addr = req.read_addr & CMASK;
						act.is_read = 1'b1;
					end
					vdma_pkg::SEL_SCROLL: begin
						act.rd_en   = 1'b1;
						act.rd_sel  = vdma_pkg::SEL_SCROLL;
						act.rd_addr = req.read_addr & SMASK;
						act.is_read = 1'b1;
					end
					default: begin
						act.is_read = 1'b0;
					end
				endcase
				if (act.is_read) begin
					act.res.status = vdma_pkg::ST_READ;
				end
			end
			default: begin
				act.res.status = vdma_pkg::ST_IGNORED;
			end
		endcase

		act.res.busy        = active_d;
		act.res.next_source = (active_d && kind_d >= vdma_pkg::K_MVID &&
		                       kind_d <= vdma_pkg::K_MSCR) ? src_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			kind_q   <= vdma_pkg::K_NONE;
			dest_q   <= '0;
			src_q    <= '0;
			left_q   <= '0;
			fill_q   <= '0;
		end else if (fire) begin
			active_q <= active_d;
			kind_q   <= kind_d;
			dest_q   <= dest_d;
			src_q    <= src_d;
			left_q   <= left_d;
			fill_q   <= fill_d;
		end
	end

endmodule

// ===== rtl/video_dma_transfer_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_dma_transfer_engine
// DMA engine over video, colour and scroll byte stores: fill, copy and
// system-memory transfers stepped one byte per request word, plus store reads.
// ----------------------------------------------------------------------------
//
//   Channel   Modport   Direction   Word
//   req       sink      in          start, step or read request
//   res       source    out         one result word per request word
//
// A request word is accepted in every cycle when the result side keeps up; its
// result word passes through stage one, where the registered store read lands,
// then the output register. The store read and write-back of a copy step overlap
// the next word through a forwarding path, so steps run back to back. After reset
// a clearing pass zeroes the stores, one entry per cycle over all VIDEO_BYTES
// video addresses (65536 by default), with req.ready low. While res.ready is low,
// a full output register holds, and a full stage one holds with req.ready low.
//
module video_dma_transfer_engine #(
	parameter int VIDEO_BYTES  = vdma_pkg::VIDEO_BYTES_DEF,
	parameter int COLOUR_BYTES = vdma_pkg::COLOUR_BYTES_DEF,
	parameter int SCROLL_BYTES = vdma_pkg::SCROLL_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vdma_req_if.sink  req,
	vdma_res_if.source res
);

	localparam int VAW = $clog2(VIDEO_BYTES);
	localparam int CAW = $clog2(COLOUR_BYTES);
	localparam int SAW = $clog2(SCROLL_BYTES);

	// Request word packed for the control unit.
	vdma_pkg::req_t req_word;
	vdma_pkg::act_t act;
	logic           in_fire;

	// Stage one: the word whose store read is in flight.
	logic                v_s1;
	vdma_pkg::act_t      act_s1;
	logic                hit_s1;
	logic [7:0]          fwd_s1;
	logic                s1_go;
	logic                s1_fire;
	logic [7:0]          rdata_s1;
	logic [7:0]          wdata_s1;

	// Output register.
	logic                out_v_q;
	vdma_pkg::res_t      out_q;
	logic [7:0]          out_rdata_q;

	// Clearing pass after reset.
	logic                clr_busy_q;
	logic [VAW-1:0]      clr_addr_q;

	logic [7:0]          vid_rd, col_rd, scr_rd;
	logic                fwd_hit;

	assign req_word = '{
		req_type:        req.req_type,
		cmd_code:        req.cmd_code,
		dest_address:    req.dest_address,
		source_value:    req.source_value,
		transfer_length: req.transfer_length,
		mem_byte:        req.mem_byte,
		mem_present:     req.mem_present,
		read_store:      req.read_store,
		read_addr:       req.read_addr
	};

	// Stage one moves on whenever the output register is empty or being taken.
	assign s1_go     = !out_v_q || res.ready;
	assign s1_fire   = v_s1 && s1_go;
	assign req.ready = !clr_busy_q && (!v_s1 || s1_go);
	assign in_fire   = req.valid && req.ready;

	vdma_ctrl #(
		.VIDEO_BYTES  (VIDEO_BYTES),
		.COLOUR_BYTES (COLOUR_BYTES),
		.SCROLL_BYTES (SCROLL_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (in_fire),
		.req    (req_word),
		.act    (act)
	);

	// Read data of stage one: the registered store output, unless the word
	// ahead wrote the same entry at the edge the read was taken.
	always_comb begin
		unique case (act_s1.rd_sel)
			vdma_pkg::SEL_COLOUR: rdata_s1 = col_rd;
			vdma_pkg::SEL_SCROLL: rdata_s1 = scr_rd;
			default:              rdata_s1 = vid_rd;
		endcase
		if (hit_s1) begin
			rdata_s1 = fwd_s1;
		end
	end

	assign wdata_s1 = act_s1.wr_copy ? rdata_s1 : act_s1.wr_byte;

	// The new word's read sees the store before the write of the word leaving
	// stage one at the same edge, so that write is forwarded.
	assign fwd_hit = v_s1 && act_s1.wr_en && act.rd_en &&
	                 act_s1.wr_sel == act.rd_sel && act_s1.wr_addr == act.rd_addr;

	vdma_ram #(.DEPTH(VIDEO_BYTES)) u_video (
		.clk     (clk),
		.wr_en   (clr_busy_q || (s1_fire && act_s1.wr_en &&
		          act_s1.wr_sel == vdma_pkg::SEL_VIDEO)),
		.wr_addr (clr_busy_q ? clr_addr_q : act_s1.wr_addr[VAW-1:0]),
		.wr_data (clr_busy_q ? 8'd0 : wdata_s1),
		.rd_en   (in_fire && act.rd_en && act.rd_sel == vdma_pkg::SEL_VIDEO),
		.rd_addr (act.rd_addr[VAW-1:0]),
		.rd_data (vid_rd)
	);

	vdma_ram #(.DEPTH(COLOUR_BYTES)) u_colour (
		.clk     (clk),
		.wr_en   (clr_busy_q || (s1_fire && act_s1.wr_en &&
		          act_s1.wr_sel == vdma_pkg::SEL_COLOUR)),
		.wr_addr (clr_busy_q ? clr_addr_q[CAW-1:0] : act_s1.wr_addr[CAW-1:0]),
		.wr_data (clr_busy_q ? 8'd0 : wdata_s1),
		.rd_en   (in_fire && act.rd_en && act.rd_sel == vdma_pkg::SEL_COLOUR),
		.rd_addr (act.rd_addr[CAW-1:0]),
		.rd_data (col_rd)
	);

	vdma_ram #(.DEPTH(SCROLL_BYTES)) u_scroll (
		.clk     (clk),
		.wr_en   (clr_busy_q || (s1_fire && act_s1.wr_en &&
		          act_s1.wr_sel == vdma_pkg::SEL_SCROLL)),
		.wr_addr (clr_busy_q ? clr_addr_q[SAW-1:0] : act_s1.wr_addr[SAW-1:0]),
		.wr_data (clr_busy_q ? 8'd0 : wdata_s1),
		.rd_en   (in_fire && act.rd_en && act.rd_sel == vdma_pkg::SEL_SCROLL),
		.rd_addr (act.rd_addr[SAW-1:0]),
		.rd_data (scr_rd)
	);

	// The video store is to be set no smaller than the other two, which the block
	// does not check; then one sweep over its addresses clears all three.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + VAW'(1);
			if (clr_addr_q == VAW'(VIDEO_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1 <= act;
			hit_s1 <= fwd_hit;
			fwd_s1 <= wdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q       <= act_s1.res;
			out_rdata_q <= act_s1.is_read ? rdata_s1 : 8'd0;
		end
	end

	assign res.valid       = out_v_q;
	assign res.busy_res    = out_q.busy;
	assign res.kind        = out_q.kind;
	assign res.next_source = out_q.next_source;
	assign res.status      = out_q.status;
	assign res.read_data   = out_rdata_q;

endmodule

// ===== tb/sv/video_dma_transfer_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_dma_transfer_engine_test
// Self-checking bench for the video DMA engine. Request words go in over the
// valid/ready channel with random gaps. A behavioral mirror of the three
// stores and the transfer registers predicts one result word per request.
// Every result word is compared field by field, in order.
// ----------------------------------------------------------------------------
module video_dma_transfer_engine_test;
	import vdma_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int WORD_TARGET = 1350;
	localparam int VMASK = VIDEO_BYTES_DEF - 1;
	localparam int CMASK = COLOUR_BYTES_DEF - 1;
	localparam int SMASK = SCROLL_BYTES_DEF - 1;

	// Codes the package leaves unnamed: bad request, store and target codes; memory modes.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] SEL_NONE = 2'd3;
	localparam logic [1:0] MODE_MEM = 2'b00;
	localparam logic [1:0] MODE_MEM_ALT = 2'b01;
	localparam logic [2:0] TGT_BAD = 3'd0;

	typedef struct {
		bit        busy;
		kind_t     kind;
		bit [31:0] next_src;
		status_t   status;
		bit [7:0]  rdata;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vdma_req_if req_ch ();
	vdma_res_if res_ch ();

	video_dma_transfer_engine uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.res   (res_ch.source)
	);

	always #5 clk = ~clk;

	// Mirror of the engine state.
	bit [7:0]  video_mem [VIDEO_BYTES_DEF];
	bit [7:0]  colour_mem [COLOUR_BYTES_DEF];
	bit [7:0]  scroll_mem [SCROLL_BYTES_DEF];
	bit        xfer_active;
	kind_t     cur_kind = K_NONE;
	bit [15:0] dest_ptr;
	bit [31:0] src_ptr;
	bit [15:0] remaining;
	bit [7:0]  fill_val;

	outcome_t pending_results [$];
	int fault_count;
	int effective_words;
	int checked_words;
	int cycle_count;
	bit gaps_on = 1'b1;

	function automatic bit [15:0] store_mask(input kind_t k);
		if (k == K_MCOL)
			return 16'(CMASK);
		if (k == K_MSCR)
			return 16'(SMASK);
		return 16'(VMASK);
	endfunction

	function automatic void halt_transfer();
		xfer_active = 1'b0;
		remaining = '0;
		cur_kind = K_NONE;
	endfunction

	// Applies one request word to the mirror and returns the result it must cause.
	function automatic outcome_t engine_outcome(input req_t w);
		outcome_t  o;
		kind_t     k;
		bit [31:0] full;
		bit [15:0] mask;
		bit [15:0] d;
		o.kind = cur_kind;
		o.status = ST_IGNORED;
		o.rdata = '0;
		case (w.req_type)
			REQ_START: begin
				full = ({24'd0, w.cmd_code} << 14) | {16'd0, w.dest_address};
				if (w.cmd_code[7:6] == MODE_FILL) begin
					k = K_FILL;
					fill_val = w.source_value[7:0];
					src_ptr = '0;
				end else if (w.cmd_code[7:6] == MODE_COPY) begin
					k = K_COPY;
					src_ptr = {16'd0, w.source_value[15:0]} & 32'(VMASK);
				end else begin
					src_ptr = w.source_value;
					case (full[18:16])
						TGT_VIDEO:  k = K_MVID;
						TGT_COLOUR: k = K_MCOL;
						TGT_SCROLL: k = K_MSCR;
						default:    k = K_NONE;
					endcase
				end
				dest_ptr = full[15:0] & store_mask(k);
				o.kind = k;
				if (k == K_NONE || w.transfer_length == 16'd0) begin
					halt_transfer();
					o.status = ST_FINISHED;
				end else begin
					cur_kind = k;
					remaining = w.transfer_length;
					xfer_active = 1'b1;
					o.status = ST_STARTED;
				end
			end
			REQ_STEP: begin
				k = cur_kind;
				mask = store_mask(k);
				d = dest_ptr & mask;
				o.kind = k;
				if (xfer_active && k != K_NONE) begin
					o.status = ST_MOVED;
					case (k)
						K_FILL: video_mem[d] = fill_val;
						K_COPY: begin
							video_mem[d] = video_mem[src_ptr[15:0] & 16'(VMASK)];
							src_ptr = (src_ptr + 32'd1) & 32'(VMASK);
						end
						default: begin
							if (!w.mem_present) begin
								// A missing memory byte drops the transfer and writes nothing.
								halt_transfer();
								o.status = ST_ABORTED;
							end else begin
								if (k == K_MVID)
									video_mem[d] = w.mem_byte;
								else if (k == K_MCOL)
									colour_mem[d] = w.mem_byte;
								else
									scroll_mem[d] = w.mem_byte;
								src_ptr = src_ptr + 32'd1;
							end
						end
					endcase
					if (o.status == ST_MOVED) begin
						dest_ptr = (d + 16'd1) & mask;
						remaining = remaining - 16'd1;
						if (remaining == 16'd0) begin
							halt_transfer();
							o.status = ST_FINISHED;
						end
					end
				end
			end
			REQ_READ: begin
				case (w.read_store)
					SEL_VIDEO: begin
						o.rdata = video_mem[w.read_addr & 16'(VMASK)];
						o.status = ST_READ;
					end
					SEL_COLOUR: begin
						o.rdata = colour_mem[w.read_addr & 16'(CMASK)];
						o.status = ST_READ;
					end
					SEL_SCROLL: begin
						o.rdata = scroll_mem[w.read_addr & 16'(SMASK)];
						o.status = ST_READ;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		o.busy = xfer_active;
		o.next_src = (xfer_active && cur_kind >= K_MVID && cur_kind <= K_MSCR) ?
			src_ptr : 32'd0;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t random_word();
		req_t w;
		w.req_type = 2'($urandom);
		w.cmd_code = 8'($urandom);
		w.dest_address = 16'($urandom);
		w.source_value = $urandom;
		w.transfer_length = 16'($urandom);
		w.mem_byte = 8'($urandom);
		w.mem_present = 1'($urandom);
		w.read_store = 2'($urandom);
		w.read_addr = 16'($urandom);
		return w;
	endfunction

	function automatic bit [7:0] cmd_byte(input logic [1:0] mode, input bit b5,
			input logic [2:0] tgt, input bit [1:0] hi);
		return {mode, b5, tgt, hi};
	endfunction

	function automatic req_t start_word(input bit [7:0] code, input bit [15:0] dest,
			input bit [31:0] src, input bit [15:0] len);
		req_t w;
		w = random_word();
		w.req_type = REQ_START;
		w.cmd_code = code;
		w.dest_address = dest;
		w.source_value = src;
		w.transfer_length = len;
		return w;
	endfunction

	function automatic req_t step_word(input bit [7:0] data, input bit present);
		req_t w;
		w = random_word();
		w.req_type = REQ_STEP;
		w.mem_byte = data;
		w.mem_present = present;
		return w;
	endfunction

	function automatic req_t read_word(input logic [1:0] sel, input bit [15:0] addr);
		req_t w;
		w = random_word();
		w.req_type = REQ_READ;
		w.read_store = sel;
		w.read_addr = addr;
		return w;
	endfunction

	// Drives one request word, waits for it to be taken and records its result.
	task automatic send_word(input req_t w);
		int gap;
		outcome_t want;
		gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= w.req_type;
		req_ch.cmd_code <= w.cmd_code;
		req_ch.dest_address <= w.dest_address;
		req_ch.source_value <= w.source_value;
		req_ch.transfer_length <= w.transfer_length;
		req_ch.mem_byte <= w.mem_byte;
		req_ch.mem_present <= w.mem_present;
		req_ch.read_store <= w.read_store;
		req_ch.read_addr <= w.read_addr;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		want = engine_outcome(w);
		pending_results.push_back(want);
		if (want.status != ST_IGNORED)
			effective_words++;
	endtask

	// Stores read back as zero after reset; odd requests and idle steps do nothing.
	task automatic test_idle_requests();
		req_t w;
		send_word(read_word(SEL_VIDEO, 16'h0000));
		send_word(read_word(SEL_VIDEO, 16'hFFFF));
		send_word(read_word(SEL_COLOUR, 16'hFFFF));
		send_word(read_word(SEL_SCROLL, 16'h0080));
		send_word(read_word(SEL_NONE, 16'h1234));
		w = random_word();
		w.req_type = REQ_UNUSED;
		send_word(w);
		send_word(step_word(8'hFF, 1'b1));
	endtask

	// Fill whose destination gets its top bits from the command code and wraps.
	task automatic test_fill_transfer();
		send_word(start_word(cmd_byte(MODE_FILL, 1'b0, TGT_BAD, 2'b11), 16'hFFFF,
			32'h0000_00A5, 16'd2));
		send_word(step_word(8'h00, 1'b0));
		send_word(step_word(8'h00, 1'b0));
		send_word(read_word(SEL_VIDEO, 16'h0000));
	endtask

	// Copy whose source starts at the top of the video store and wraps to zero.
	task automatic test_copy_transfer();
		send_word(start_word(cmd_byte(MODE_COPY, 1'b0, TGT_BAD, 2'b00), 16'h0100,
			32'hABCD_FFFF, 16'd2));
		send_word(step_word(8'h00, 1'b1));
		send_word(step_word(8'h00, 1'b1));
		send_word(read_word(SEL_VIDEO, 16'h0101));
	endtask

	// Memory transfer into the colour store: destination and 32-bit source both
	// wrap, and a missing memory byte aborts it.
	task automatic test_memory_transfers();
		send_word(start_word(cmd_byte(MODE_MEM, 1'b0, TGT_COLOUR, 2'b00), 16'h007F,
			32'hFFFF_FFFF, 16'd3));
		send_word(step_word(8'hFF, 1'b1));
		send_word(step_word(8'h00, 1'b1));
		send_word(step_word(8'h5A, 1'b0));
		send_word(read_word(SEL_COLOUR, 16'h007F));
	endtask

	// Start replacing a running transfer, an invalid target, a zero length.
	task automatic test_start_cases();
		send_word(start_word(cmd_byte(MODE_MEM_ALT, 1'b1, TGT_SCROLL, 2'b11), 16'hFFFF,
			32'h8000_0000, 16'hFFFF));
		send_word(step_word(8'h3C, 1'b1));
		send_word(start_word(cmd_byte(MODE_MEM, 1'b0, TGT_BAD, 2'b01), 16'h0040,
			32'h1234_5678, 16'd5));
		send_word(start_word(cmd_byte(MODE_MEM, 1'b0, TGT_VIDEO, 2'b00), 16'h0200,
			32'h0000_0010, 16'd0));
		send_word(start_word(8'hFF, 16'h0000, 32'h0000_0000, 16'd1));
		send_word(step_word(8'h00, 1'b1));
	endtask

	// Mostly complete transfers with random content and reads of what they wrote;
	// the rest are random starts, reads and stray words.
	task automatic test_random_traffic();
		int pick;
		int k_sel;
		int len;
		int steps;
		bit near;
		bit [7:0] code;
		bit [15:0] dest;
		bit [31:0] src;
		logic [1:0] sel;
		req_t w;
		while (effective_words < WORD_TARGET) begin
			if ($urandom_range(0, 19) == 0)
				gaps_on = !gaps_on;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				k_sel = $urandom_range(0, 4);
				near = $urandom_range(0, 3) != 0;
				code = 8'($urandom);
				case (k_sel)
					0: code[7:6] = MODE_FILL;
					1: code[7:6] = MODE_COPY;
					2: code = cmd_byte({1'b0, 1'($urandom)}, 1'($urandom), TGT_VIDEO,
						2'($urandom));
					3: code = cmd_byte({1'b0, 1'($urandom)}, 1'($urandom), TGT_COLOUR,
						2'($urandom));
					default: code = cmd_byte({1'b0, 1'($urandom)}, 1'($urandom),
						TGT_SCROLL, 2'($urandom));
				endcase
				sel = (k_sel == 3) ? SEL_COLOUR : (k_sel == 4) ? SEL_SCROLL : SEL_VIDEO;
				dest = 16'($urandom);
				src = $urandom;
				// Keep most transfers in one small window so copies see filled bytes.
				if (near) begin
					code[1:0] = 2'b00;
					dest = 16'($urandom_range(0, 511));
					src[15:0] = 16'($urandom_range(0, 511));
				end
				pick = $urandom_range(0, 99);
				if (pick < 90)
					len = $urandom_range(1, 16);
				else if (pick < 96)
					len = $urandom_range(17, 300);
				else
					len = $urandom_range(0, 65535);
				steps = (len <= 300 && $urandom_range(0, 9) != 0) ? len :
					$urandom_range(0, 16);
				send_word(start_word(code, dest, src, 16'(len)));
				for (int i = 0; i < steps && xfer_active; i++) begin
					if ($urandom_range(0, 99) < 15)
						send_word(read_word(sel, dest_ptr - 16'd1));
					send_word(step_word(8'($urandom), $urandom_range(0, 49) != 0));
				end
				if ($urandom_range(0, 9) < 4)
					send_word(read_word(sel, 16'($urandom_range(0, 511))));
			end else if (pick < 82) begin
				w = random_word();
				w.req_type = REQ_START;
				send_word(w);
			end else if (pick < 92) begin
				w = random_word();
				w.req_type = REQ_READ;
				send_word(w);
			end else begin
				send_word(random_word());
			end
		end
	endtask

	// Result side: stalls of random length, none started while gaps are switched off.
	always @(posedge clk) begin : result_pacing
		int stall_left;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 99) < 20) begin
			stall_left = pick_gap() - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Each accepted result word is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		outcome_t want;
		bit bad;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result word %0d arrived with nothing pending", checked_words);
			end else begin
				want = pending_results.pop_front();
				bad = res_ch.busy_res !== want.busy || res_ch.kind !== want.kind ||
					res_ch.next_source !== want.next_src ||
					res_ch.status !== want.status || res_ch.read_data !== want.rdata;
				if (bad) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"result word %0d (expected/actual): busy %0b/%0b",
							" kind %0d/%0d next_source %h/%h status %0d/%0d",
							" read_data %h/%h"}, checked_words,
							want.busy, res_ch.busy_res, want.kind, res_ch.kind,
							want.next_src, res_ch.next_source, want.status,
							res_ch.status, want.rdata, res_ch.read_data);
				end
			end
			checked_words++;
		end
	end

	// The clearing pass after reset takes a small part of the budget; the rest is ample.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_START;
		req_ch.cmd_code <= '0;
		req_ch.dest_address <= '0;
		req_ch.source_value <= '0;
		req_ch.transfer_length <= '0;
		req_ch.mem_byte <= '0;
		req_ch.mem_present <= 1'b0;
		req_ch.read_store <= SEL_VIDEO;
		req_ch.read_addr <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_requests();
		test_fill_transfer();
		test_copy_transfer();
		test_memory_transfers();
		test_start_cases();
		test_random_traffic();

		// Drain: every predicted word must come back, then a short quiet spell.
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vdma_pkg.sv
rtl/vdma_ifs.sv
rtl/vdma_ram.sv
rtl/vdma_ctrl.sv
rtl/video_dma_transfer_engine.sv
tb/sv/video_dma_transfer_engine_test.sv
